// ----- rtl/sact_pkg.sv -----
// package for the set-associative tag store with lru replacement
// constants, action codes and controller command/status structs; no dependencies
package sact_pkg;

  localparam int unsigned DefNumSets     = 64;
  localparam int unsigned DefNumWays     = 4;
  localparam int unsigned DefBlockBytes  = 64;
  localparam int unsigned DefAddressBits = 32;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned TimeW  = 31;
  localparam int unsigned RangeW = 17;
  localparam int unsigned CountW = 32;

  typedef enum logic [1:0] {
    ACT_LOOKUP  = 2'd0,
    ACT_INSTALL = 2'd1,
    ACT_FLUSH   = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  // controller to datapath commands
  typedef struct packed {
    logic    load;      // capture incoming transaction
    logic    read;      // read addressed set
    logic    exec;      // apply action to read set
    logic    clr_step;  // clear one set at the sweep address
    logic    clr_start; // reset the sweep counter and counters
    logic    step;      // advance flush probe
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic    flush_done; // no probe left
    logic    clr_done;   // last set being cleared
  } stat_t;

endpackage

// ----- rtl/sact_datapath.sv -----
// datapath: per-set tag memory, hit/victim logic, flush probe and counters
// depends on sact_pkg
module sact_datapath
  import sact_pkg::*;
#(
  parameter int unsigned NumSets     = DefNumSets,
  parameter int unsigned NumWays     = DefNumWays,
  parameter int unsigned BlockBytes  = DefBlockBytes,
  parameter int unsigned AddressBits = DefAddressBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [1:0]        action_i,
  input  logic [AddrW-1:0]  address_i,
  input  logic [TimeW-1:0]  access_time_i,
  input  logic [RangeW-1:0] range_bytes_i,
  output logic [1:0]        action_o,
  output logic              hit_o,
  output logic [CountW-1:0] hit_count_o,
  output logic [CountW-1:0] miss_count_o
);

  localparam int unsigned OffW  = $clog2(BlockBytes);
  localparam int unsigned SetW  = (NumSets > 1) ? $clog2(NumSets) : 1;
  localparam int unsigned SetB  = $clog2(NumSets);
  localparam int unsigned TagW  = (AddressBits > OffW + SetB) ? AddressBits - OffW - SetB : 1;
  localparam int unsigned WayW  = (NumWays > 1) ? $clog2(NumWays) : 1;
  localparam int unsigned LineW = 1 + TagW + TimeW;
  localparam int unsigned RowW  = NumWays * LineW;
  localparam int unsigned OffsW = RangeW + 1;

  // row memory: one word per set holding all ways
  logic [RowW-1:0] mem [NumSets];
  logic [RowW-1:0] row_q;

  logic [1:0]        act_q;
  logic [AddrW-1:0]  base_q;
  logic [TimeW-1:0]  time_q;
  logic [RangeW-1:0] len_q;
  logic [OffsW-1:0]  off_q, off_d;
  logic [SetW-1:0]   sweep_q;
  logic [CountW-1:0] hits_q, misses_q;
  logic              hit_q;

  // current probe address, masked to address width
  logic [AddrW-1:0] probe;
  logic [AddrW-1:0] amask;
  logic [SetW-1:0]  set_idx;
  logic [TagW-1:0]  tag;
  assign amask = (AddressBits >= AddrW) ? '1 : AddrW'((64'd1 << AddressBits) - 64'd1);
  assign probe = (base_q + AddrW'(off_q)) & amask;
  always_comb begin
    logic [AddrW-1:0] sh;
    sh = probe >> OffW;
    set_idx = (NumSets > 1) ? SetW'(sh) : '0;
    tag = TagW'(probe >> (OffW + SetB));
  end

  // per-way compare and victim choice
  logic [NumWays-1:0] match;
  logic [NumWays-1:0] inval;
  logic [WayW-1:0]    hit_way, free_way, lru_way;
  logic               any_hit, any_free;
  logic [RowW-1:0]    new_row;

  always_comb begin
    logic [TimeW-1:0] best;
    any_hit = 1'b0; any_free = 1'b0;
    hit_way = '0; free_way = '0; lru_way = '0;
    best = row_q[TimeW-1:0];
    for (int w = 0; w < NumWays; w++) begin
      match[w] = row_q[w*LineW + LineW-1] &&
                 (row_q[w*LineW + TimeW +: TagW] == tag);
      inval[w] = !row_q[w*LineW + LineW-1];
    end
    for (int w = NumWays-1; w >= 0; w--) begin
      if (match[w]) begin any_hit = 1'b1; hit_way = WayW'(w); end
      if (inval[w]) begin any_free = 1'b1; free_way = WayW'(w); end
    end
    for (int w = 1; w < NumWays; w++) begin
      if (row_q[w*LineW +: TimeW] < best) begin
        best = row_q[w*LineW +: TimeW];
        lru_way = WayW'(w);
      end
    end
  end

  // updated row for the action
  always_comb begin
    logic [WayW-1:0] pick;
    new_row = row_q;
    pick = any_free ? free_way : lru_way;
    unique case (action_e'(act_q))
      ACT_LOOKUP: begin
        if (any_hit) new_row[hit_way*LineW +: TimeW] = time_q;
      end
      ACT_INSTALL: begin
        new_row[pick*LineW +: LineW] = {1'b1, tag, time_q};
      end
      ACT_FLUSH: begin
        for (int w = 0; w < NumWays; w++)
          if (match[w]) new_row[w*LineW + LineW-1] = 1'b0;
      end
      default: new_row = row_q;
    endcase
  end

  // memory port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) mem[sweep_q] <= '0;
    else if (cmd_i.exec) mem[set_idx] <= new_row;
    if (cmd_i.read) row_q <= mem[set_idx];
  end

  // captured transaction payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      base_q <= address_i;
      time_q <= access_time_i;
      len_q  <= range_bytes_i;
    end
  end

  assign off_d = off_q + OffsW'(BlockBytes);

  // control registers: probe offset, sweep, counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; sweep_q <= '0; hits_q <= '0; misses_q <= '0; hit_q <= 1'b0;
    end else begin
      if (cmd_i.load) off_q <= '0;
      else if (cmd_i.step) off_q <= off_d;
      if (cmd_i.clr_start) begin
        sweep_q <= '0; hits_q <= '0; misses_q <= '0;
      end else if (cmd_i.clr_step) begin
        sweep_q <= sweep_q + SetW'(1);
      end
      if (cmd_i.load) hit_q <= 1'b0;
      if (cmd_i.exec && act_q == ACT_LOOKUP) begin
        hit_q <= any_hit;
        if (any_hit) begin
          if (hits_q != '1) hits_q <= hits_q + CountW'(1);
        end else if (misses_q != '1) begin
          misses_q <= misses_q + CountW'(1);
        end
      end
    end
  end

  assign stat_o.flush_done = (OffsW'(len_q) <= off_q);
  assign stat_o.clr_done   = (NumSets <= 1) || (sweep_q == SetW'(NumSets-1));
  assign action_o     = act_q;
  assign hit_o        = hit_q;
  assign hit_count_o  = hits_q;
  assign miss_count_o = misses_q;

endmodule

// ----- rtl/sact_ctrl.sv -----
// controller state machine sequencing read, update, flush probes and clear sweep
// depends on sact_pkg
module sact_ctrl
  import sact_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  logic [1:0] action_i,
  input  logic [1:0] cur_action_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE) || (state_q == S_OUT && out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_OUT);
  assign busy_o      = (state_q != S_IDLE) && (state_q != S_OUT);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE, S_OUT: begin
        if (state_q == S_OUT && out_ready_i) state_d = S_IDLE;
        if (accept) begin
          cmd_o.load = 1'b1;
          if (action_i == ACT_CLEAR) begin
            cmd_o.clr_start = 1'b1;
            state_d = S_CLEAR;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        if (cur_action_i == ACT_FLUSH && stat_i.flush_done) begin
          state_d = S_OUT;
        end else begin
          cmd_o.read = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (cur_action_i == ACT_FLUSH) begin
          cmd_o.step = 1'b1;
          state_d = S_READ;
        end else begin
          state_d = S_OUT;
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = S_OUT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

// ----- rtl/set_assoc_cache_tags_lru_unit.sv -----
// set-associative tag store with lru replacement; one transaction in flight.
// lookup and install: accept, then read set, update and output the result.
// flush: one memory read/write per probe, one probe per block of range_bytes.
// clear: one set row zeroed per cycle; next accept when result leaves.
// reset: async active low, counters zero; the tag memory is swept clear before first accept.
module set_assoc_cache_tags_lru_unit
  import sact_pkg::*;
#(
  parameter int unsigned NUM_SETS     = DefNumSets,
  parameter int unsigned NUM_WAYS     = DefNumWays,
  parameter int unsigned BLOCK_BYTES  = DefBlockBytes,
  parameter int unsigned ADDRESS_BITS = DefAddressBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,  // address[31:0], access_time[62:32], range_bytes[79:63]
  input  logic [1:0]   s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // hit_count[31:0], miss_count[63:32]
  output logic         m_axis_tuser   // hit
);

  cmd_t       cmd, cmd_ctl;
  stat_t      stat;
  logic [1:0] cur_act;
  logic       busy;
  logic       init_q;
  logic       rdy_ctl;
  logic [CountW-1:0] hc, mc;

  // power-up sweep clears the memory before the first transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) init_q <= 1'b1;
    else if (init_q && stat.clr_done) init_q <= 1'b0;
  end

  always_comb begin
    cmd = cmd_ctl;
    if (init_q) begin
      cmd = '0;
      cmd.clr_step = 1'b1;
    end
  end

  sact_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid && !init_q),
    .in_ready_o   (rdy_ctl),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .action_i     (s_axis_tuser),
    .cur_action_i (cur_act),
    .stat_i       (stat),
    .cmd_o        (cmd_ctl),
    .busy_o       (busy)
  );

  sact_datapath #(
    .NumSets     (NUM_SETS),
    .NumWays     (NUM_WAYS),
    .BlockBytes  (BLOCK_BYTES),
    .AddressBits (ADDRESS_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (s_axis_tuser),
    .address_i     (s_axis_tdata[31:0]),
    .access_time_i (s_axis_tdata[62:32]),
    .range_bytes_i (s_axis_tdata[79:63]),
    .action_o      (cur_act),
    .hit_o         (m_axis_tuser),
    .hit_count_o   (hc),
    .miss_count_o  (mc)
  );

  assign s_axis_tready = rdy_ctl && !init_q;
  assign m_axis_tdata  = {mc, hc};

  // no accept while an action is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> !s_axis_tready)
    else $error("accept while busy");
  // hit only reported for lookups
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> cur_act == ACT_LOOKUP)
    else $error("hit on non-lookup");
  // clear result shows zero counters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && cur_act == ACT_CLEAR |-> hc == '0 && mc == '0)
    else $error("clear left counters");

endmodule
